>>> sv/cbor_hd_pkg.sv
// Shared types and constants for the CBOR item-head decoder.
package cbor_hd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned MajorW = 3;
  localparam int unsigned MinorW = 5;
  localparam int unsigned ArgW   = 64;
  localparam int unsigned PendW  = 4;

  localparam logic [MinorW-1:0] MINOR_EMBED_LAST    = 5'd23;
  localparam logic [MinorW-1:0] MINOR_ONE_FOLLOWS   = 5'd24;
  localparam logic [MinorW-1:0] MINOR_EIGHT_FOLLOWS = 5'd27;
  localparam logic [MinorW-1:0] MINOR_INDEFINITE    = 5'd31;

  typedef struct packed {
    logic [PendW-1:0]  pending;
    logic [MajorW-1:0] major;
    logic [MinorW-1:0] minor;
    logic [ArgW-1:0]   accum;
  } hd_state_t;

  typedef struct packed {
    logic              emit;
    logic [MajorW-1:0] major;
    logic [MinorW-1:0] minor;
    logic [ArgW-1:0]   arg;
    logic              err;
  } hd_result_t;

endpackage

>>> sv/cbor_hd_step.sv
// Combinational decode of one stream byte against the current head state.
module cbor_hd_step (
  input  cbor_hd_pkg::hd_state_t          state_i,
  input  logic [cbor_hd_pkg::ByteW-1:0]   byte_i,
  output cbor_hd_pkg::hd_state_t          state_o,
  output cbor_hd_pkg::hd_result_t         result_o
);
  import cbor_hd_pkg::*;

  logic [MajorW-1:0] byte_major;
  logic [MinorW-1:0] byte_minor;
  logic [ArgW-1:0]   accum_shift;

  assign byte_major  = byte_i[ByteW-1:MinorW];
  assign byte_minor  = byte_i[MinorW-1:0];
  assign accum_shift = {state_i.accum[ArgW-ByteW-1:0], byte_i};

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (state_i.pending != '0) begin
      state_o.accum   = accum_shift;
      state_o.pending = state_i.pending - 4'd1;
      result_o.emit   = (state_i.pending == 4'd1);
      result_o.major  = state_i.major;
      result_o.minor  = state_i.minor;
      result_o.arg    = accum_shift;
    end else if (byte_minor <= MINOR_EMBED_LAST || byte_minor == MINOR_INDEFINITE) begin
      result_o.emit  = 1'b1;
      result_o.major = byte_major;
      result_o.minor = byte_minor;
      result_o.arg   = {{(ArgW-MinorW){1'b0}}, byte_minor};
    end else if (byte_minor <= MINOR_EIGHT_FOLLOWS) begin
      state_o.major   = byte_major;
      state_o.minor   = byte_minor;
      state_o.accum   = '0;
      state_o.pending = PendW'(4'd1 << byte_minor[1:0]);
    end else begin
      result_o.emit  = 1'b1;
      result_o.major = byte_major;
      result_o.minor = byte_minor;
      result_o.err   = 1'b1;
    end
  end

endmodule

>>> sv/cbor_head_decoder.sv
// Top level of the CBOR item-head decoder.
//
// The input channel (in_valid, in_ready, in_byte) carries one stream byte per
// transaction. An initial byte with an embedded argument, the indefinite code
// or a reserved code yields one result transaction; codes 24 to 27 yield one
// result after the last of their 1, 2, 4 or 8 big-endian argument bytes.
// The result channel carries major type, minor code, the 64-bit argument and
// a reserved-code error flag.
// A result appears on the output register in the cycle after the byte that
// completes it is accepted. One byte can be accepted every cycle unless a
// waiting result is stalled; the single output register sets that.
// While the receiver stalls a waiting result, in_ready drops until it is
// taken; a result and a new byte can cross in the same cycle.
// Reset (rst_n low, synchronous) returns the decoder to awaiting an initial
// byte and empties the output register.
module cbor_head_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cbor_hd_pkg::ByteW-1:0]    in_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cbor_hd_pkg::MajorW-1:0]   out_major_type,
  output logic [cbor_hd_pkg::MinorW-1:0]   out_minor_code,
  output logic [cbor_hd_pkg::ArgW-1:0]     out_arg_value,
  output logic                             out_reserved_error
);
  import cbor_hd_pkg::*;

  hd_state_t  state_r, state_nxt;
  hd_result_t step_res;
  logic       out_valid_r;
  logic [MajorW-1:0] major_r;
  logic [MinorW-1:0] minor_r;
  logic [ArgW-1:0]   arg_r;
  logic              err_r;
  logic              in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  cbor_hd_step u_step (
    .state_i  (state_r),
    .byte_i   (in_byte),
    .state_o  (state_nxt),
    .result_o (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire && step_res.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && step_res.emit) begin
      major_r <= step_res.major;
      minor_r <= step_res.minor;
      arg_r   <= step_res.arg;
      err_r   <= step_res.err;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_major_type     = major_r;
  assign out_minor_code     = minor_r;
  assign out_arg_value      = arg_r;
  assign out_reserved_error = err_r;

  a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pending == 4'd0 || state_r.pending == 4'd1 || state_r.pending == 4'd2 ||
    state_r.pending == 4'd3 || state_r.pending == 4'd4 || state_r.pending == 4'd5 ||
    state_r.pending == 4'd6 || state_r.pending == 4'd7 || state_r.pending == 4'd8)
    else $error("argument byte count out of range");

  a_held_minor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pending != 4'd0 |->
      (state_r.minor >= MINOR_ONE_FOLLOWS && state_r.minor <= MINOR_EIGHT_FOLLOWS))
    else $error("pending argument bytes without a following-bytes code");

  a_last_byte_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && state_r.pending == 4'd1 |=> out_valid_r && !err_r)
    else $error("last argument byte gave no result");

  a_reserved_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && err_r |-> arg_r == '0 && minor_r > MINOR_EIGHT_FOLLOWS &&
      minor_r != MINOR_INDEFINITE)
    else $error("reserved-code result malformed");

  a_embedded_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (minor_r <= MINOR_EMBED_LAST || minor_r == MINOR_INDEFINITE) |->
      arg_r == {{(ArgW-MinorW){1'b0}}, minor_r} && !err_r)
    else $error("embedded argument does not match minor code");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the CBOR item-head decoder, driving byte streams.
`timescale 1ns / 100ps

module tb;
  import cbor_hd_pkg::*;

  localparam int unsigned CycleLimit = 150000;
  localparam int unsigned MaxShown   = 20;
  localparam logic [MinorW-1:0] MINOR_RESERVED_FIRST = 5'd28;
  localparam logic [MinorW-1:0] MINOR_RESERVED_LAST  = 5'd30;

  typedef struct packed {
    logic [MajorW-1:0] major;
    logic [MinorW-1:0] minor;
    logic [ArgW-1:0]   arg;
    logic              err;
  } head_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [ByteW-1:0]    in_byte;
  logic                out_valid;
  logic                out_ready;
  logic [MajorW-1:0]   out_major_type;
  logic [MinorW-1:0]   out_minor_code;
  logic [ArgW-1:0]     out_arg_value;
  logic                out_reserved_error;

  head_t               expected_heads[$];
  head_t               oldest_head;
  logic [PendW-1:0]    pend_count;
  logic [MajorW-1:0]   pend_major;
  logic [MinorW-1:0]   pend_minor;
  logic [ArgW-1:0]     pend_accum;

  int unsigned         n_errors;
  int unsigned         n_bytes;
  int unsigned         n_heads;
  int unsigned         n_reserved;
  int unsigned         n_cycles;
  bit                  no_gaps;

  cbor_head_decoder u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_major_type     (out_major_type),
    .out_minor_code     (out_minor_code),
    .out_arg_value      (out_arg_value),
    .out_reserved_error (out_reserved_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d heads outstanding.", n_cycles,
               expected_heads.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic bit gap_now();
    return !no_gaps && ($urandom_range(99) < 9);
  endfunction

  task automatic report_mismatch(string what, logic [ArgW-1:0] got, logic [ArgW-1:0] want);
    n_errors++;
    if (n_errors <= MaxShown) begin
      $display("Mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", n_cycles, what, got, want);
    end
  endtask

  function automatic void decode_byte(logic [ByteW-1:0] b);
    head_t h;
    if (pend_count != '0) begin
      pend_accum = {pend_accum[ArgW-ByteW-1:0], b};
      pend_count = pend_count - PendW'(1);
      if (pend_count == '0) begin
        h = '{major: pend_major, minor: pend_minor, arg: pend_accum, err: 1'b0};
        expected_heads.push_back(h);
      end
    end else begin
      h.major = b[ByteW-1 -: MajorW];
      h.minor = b[MinorW-1:0];
      if (h.minor <= MINOR_EMBED_LAST || h.minor == MINOR_INDEFINITE) begin
        h.arg = ArgW'(h.minor);
        h.err = 1'b0;
        expected_heads.push_back(h);
      end else if (h.minor <= MINOR_EIGHT_FOLLOWS) begin
        pend_major = h.major;
        pend_minor = h.minor;
        pend_accum = '0;
        pend_count = PendW'(1) << (h.minor - MINOR_ONE_FOLLOWS);
      end else begin
        h.arg = '0;
        h.err = 1'b1;
        expected_heads.push_back(h);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_heads.size() == 0) begin
        report_mismatch("unexpected head, argument", out_arg_value, '0);
      end else begin
        oldest_head = expected_heads.pop_front();
        if (out_major_type !== oldest_head.major)
          report_mismatch("major type", ArgW'(out_major_type), ArgW'(oldest_head.major));
        if (out_minor_code !== oldest_head.minor)
          report_mismatch("minor code", ArgW'(out_minor_code), ArgW'(oldest_head.minor));
        if (out_arg_value !== oldest_head.arg)
          report_mismatch("argument", out_arg_value, oldest_head.arg);
        if (out_reserved_error !== oldest_head.err)
          report_mismatch("reserved error", ArgW'(out_reserved_error),
                          ArgW'(oldest_head.err));
        if (oldest_head.err) n_reserved++;
      end
      n_heads++;
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= !gap_now();
    end
  end

  task automatic send_byte(logic [ByteW-1:0] b);
    @(negedge clk);
    while (gap_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    decode_byte(b);
    n_bytes++;
  endtask

  function automatic logic [ByteW-1:0] arg_byte();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    return ByteW'($urandom);
  endfunction

  task automatic send_head();
    logic [MajorW-1:0] mj;
    logic [MinorW-1:0] mn;
    int unsigned       pick;
    mj   = MajorW'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_byte(ByteW'($urandom));
      return;
    end
    if (pick < 35)      mn = MinorW'($urandom_range(MINOR_EMBED_LAST));
    else if (pick < 42) mn = MINOR_INDEFINITE;
    else if (pick < 88) mn = MINOR_ONE_FOLLOWS + MinorW'($urandom_range(3));
    else mn = MinorW'($urandom_range(MINOR_RESERVED_LAST, MINOR_RESERVED_FIRST));
    send_byte({mj, mn});
    if (mn >= MINOR_ONE_FOLLOWS && mn <= MINOR_EIGHT_FOLLOWS) begin
      repeat (1 << (mn - MINOR_ONE_FOLLOWS)) send_byte(arg_byte());
    end
  endtask

  task automatic wait_for_heads();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_heads.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [ByteW-1:0] stream[$];
    stream = '{8'h00, 8'h17, 8'hFF, 8'h1C, 8'h3D, 8'hFE,
               8'h18, 8'hFF,
               8'h39, 8'h00, 8'h00,
               8'h5A, 8'h80, 8'h1C, 8'h01, 8'hFE,
               8'hFB, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    foreach (stream[i]) send_byte(stream[i]);
  endtask

  task automatic test_random_stream(int unsigned target);
    int unsigned stop_at;
    stop_at = n_bytes + target;
    while (n_bytes < stop_at) send_head();
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    test_random_stream(200);
    no_gaps = 1'b0;
  endtask

  task automatic test_pause_and_drain();
    repeat (6) begin
      repeat ($urandom_range(6, 1)) send_head();
      wait_for_heads();
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte    = '0;
    no_gaps    = 1'b0;
    n_errors   = 0;
    n_bytes    = 0;
    n_heads    = 0;
    n_reserved = 0;
    n_cycles   = 0;
    pend_count = '0;
    pend_major = '0;
    pend_minor = '0;
    pend_accum = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_stream(450);
    test_back_to_back();
    test_pause_and_drain();
    test_random_stream(120);

    wait_for_heads();
    repeat (8) @(posedge clk);
    if (expected_heads.size() != 0)
      report_mismatch("heads left undelivered", ArgW'(expected_heads.size()), '0);
    $display("Streamed %0d bytes and checked %0d heads, %0d of them reserved codes.",
             n_bytes, n_heads, n_reserved);
    $display("Covered every minor class, extreme arguments, stalls and gap-free bursts.");
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
